// ===== rtl/bwq_pkg.sv =====
// shared types and constants for the berth allocator with wait queue
`timescale 1ns / 1ps

package bwq_pkg;

   localparam int SLOTS_DEF      = 16;
   localparam int WAIT_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF    = 16;

   localparam int COUNT_W    = 5;
   localparam int SLOT_NUM_W = 5;
   localparam int LEVEL_W    = 5;
   localparam int STATUS_W   = 3;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 5'd16;

   typedef enum logic {
      REG_SLOT_COUNT = 1'b0,
      REG_UNUSED     = 1'b1
   } reg_index_type;

   typedef enum logic {
      MODE_ARRIVE  = 1'b0,
      MODE_RELEASE = 1'b1
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PLACED   = 3'd0,
      ST_QUEUED   = 3'd1,
      ST_FREED    = 3'd2,
      ST_REFILLED = 3'd3,
      ST_DROPPED  = 3'd4,
      ST_BAD_SLOT = 3'd5
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } ring_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ring_stat_type;

endpackage

// ===== rtl/bwq_slot_map.sv =====
// occupancy flags of the slots and lowest free slot search
`timescale 1ns / 1ps

module bwq_slot_map import bwq_pkg::*; #(
   parameter  int SLOTS = SLOTS_DEF,
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int CW    = $clog2(SLOTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          set_en,
   input  logic          clr_en,
   input  logic [SW-1:0] idx,
   input  logic [CW-1:0] count,
   output logic          free_found,
   output logic [SW-1:0] free_idx
);

   logic [SLOTS-1:0] occ_ff;
   logic [SLOTS-1:0] occ_in;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!occ_ff[i] && (i < int'(count))) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (set_en) begin
         occ_in[idx] = 1'b1;
      end
      if (clr_en) begin
         occ_in[idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

endmodule

// ===== rtl/bwq_wait_ring.sv =====
// fifo wait queue held in a synchronous memory with head read forwarding
`timescale 1ns / 1ps

module bwq_wait_ring import bwq_pkg::*; #(
   parameter  int WAIT_DEPTH = WAIT_DEPTH_DEF,
   parameter  int ID_BITS    = ID_BITS_DEF,
   localparam int QW         = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1,
   localparam int FW         = $clog2(WAIT_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  ring_cmd_type       cmd,
   input  logic [ID_BITS-1:0] wdata,
   output ring_stat_type      stat,
   output logic [ID_BITS-1:0] head_data,
   output logic [FW-1:0]      fill
);

   logic [ID_BITS-1:0] mem [WAIT_DEPTH];

   logic [QW-1:0]      head_ff;
   logic [QW-1:0]      head_in;
   logic [QW-1:0]      tail_ff;
   logic [QW-1:0]      tail_in;
   logic [FW-1:0]      fill_ff;
   logic [FW-1:0]      fill_in;
   logic [ID_BITS-1:0] rdata_ff;
   logic               fwd_ff;
   logic [ID_BITS-1:0] fwd_data_ff;

   function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] ptr);
      logic [QW-1:0] nxt;
      nxt = (ptr == QW'(WAIT_DEPTH - 1)) ? '0 : ptr + 1'b1;
      return nxt;
   endfunction

   always_comb begin
      head_in = cmd.pop ? ring_next(head_ff) : head_ff;
      tail_in = cmd.push ? ring_next(tail_ff) : tail_ff;
      fill_in = fill_ff;
      if (cmd.push && !cmd.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // head entry is read every cycle, a write to the same entry is forwarded
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[tail_ff] <= wdata;
      end
      rdata_ff    <= mem[head_in];
      fwd_ff      <= cmd.push && (tail_ff == head_in);
      fwd_data_ff <= wdata;
   end

   assign head_data  = fwd_ff ? fwd_data_ff : rdata_ff;
   assign fill       = fill_ff;
   assign stat.full  = (fill_ff == FW'(WAIT_DEPTH));
   assign stat.empty = (fill_ff == '0);

endmodule

// ===== rtl/berth_allocator_with_wait_queue.sv =====
// top level of the berth allocator with wait queue
//
// input channel req_*: one item per transfer, mode 0 arrives requester_id at the
// lowest free slot (or queues it, or drops it when the queue is full), mode 1 releases slot_number and moves the
// queue head into it when the queue holds an entry
// result channel rsp_*: exactly one result per item, in item order
// configuration: apb write of slot_count at byte address 0, reads return it
// path: an accepted item is held in the execute register and its result is
// offered from the output register
// throughput: one item per cycle while req_stall is low; the queue head read from the wait memory
// is kept current every cycle, so back-to-back items need no bubble
// stall: an output register holds a stalled result while one more item waits
// in the execute register; req_stall rises only when both are full
// reset: synchronous, clears all slots to free, empties the queue and sets
// slot_count to 16; no clearing pass is needed
`timescale 1ns / 1ps

module berth_allocator_with_wait_queue import bwq_pkg::*; #(
   parameter  int SLOTS      = SLOTS_DEF,
   parameter  int WAIT_DEPTH = WAIT_DEPTH_DEF,
   parameter  int ID_BITS    = ID_BITS_DEF,
   localparam int SW         = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int CW         = $clog2(SLOTS + 1),
   localparam int FW         = $clog2(WAIT_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [ID_BITS-1:0]    req_requester_id,
   input  logic [SLOT_NUM_W-1:0] req_slot_number,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_NUM_W-1:0] rsp_slot_out,
   output logic [ID_BITS-1:0]    rsp_id_out,
   output logic [LEVEL_W-1:0]    rsp_queue_level,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_AW-1:0]     paddr,
   input  logic [CSR_DW-1:0]     pwdata,
   output logic [CSR_DW-1:0]     prdata,
   output logic                  pready
);

   logic [COUNT_W-1:0]    slot_count_ff;
   logic [CW-1:0]         count_eff;
   reg_index_type         csr_idx;

   logic                  accept;
   logic                  commit;
   logic                  s1_go;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   mode_type              s1_mode_ff;
   logic [ID_BITS-1:0]    s1_id_ff;
   logic [SLOT_NUM_W-1:0] s1_slot_ff;

   logic                  free_found;
   logic [SW-1:0]         free_idx;
   logic                  map_set;
   logic                  map_clr;
   logic [SW-1:0]         map_idx;
   logic [SW-1:0]         rel_idx;
   logic                  bad_slot;

   ring_cmd_type          ring_cmd;
   ring_stat_type         ring_stat;
   logic [ID_BITS-1:0]    head_data;
   logic [FW-1:0]         fill;
   logic [FW-1:0]         level;

   status_type            status_in;
   logic [SLOT_NUM_W-1:0] slot_out_in;
   logic [ID_BITS-1:0]    id_out_in;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [SLOT_NUM_W-1:0] rsp_slot_out_ff;
   logic [ID_BITS-1:0]    rsp_id_out_ff;
   logic [LEVEL_W-1:0]    rsp_queue_level_ff;

   // configuration port
   assign csr_idx = reg_index_type'(paddr[2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RST;
      end else if (psel && penable && pwrite && (csr_idx == REG_SLOT_COUNT)) begin
         slot_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SLOT_COUNT: prdata = CSR_DW'(slot_count_ff);
         default:        prdata = '0;
      endcase
   end

   always_comb begin
      if (slot_count_ff == '0) begin
         count_eff = CW'(1);
      end else if (int'(slot_count_ff) > SLOTS) begin
         count_eff = CW'(SLOTS);
      end else begin
         count_eff = CW'(slot_count_ff);
      end
   end

   // execute register and output register
   assign s1_go       = !rsp_valid_ff || !rsp_stall;
   assign commit      = s1_valid_ff && s1_go;
   assign req_stall   = s1_valid_ff && !s1_go;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff <= mode_type'(req_mode);
         s1_id_ff   <= req_requester_id;
         s1_slot_ff <= req_slot_number;
      end
   end

   assign rel_idx  = SW'(s1_slot_ff - 1'b1);
   assign bad_slot = (s1_slot_ff == '0) || (int'(s1_slot_ff) > int'(count_eff));

   always_comb begin
      map_set       = 1'b0;
      map_clr       = 1'b0;
      map_idx       = rel_idx;
      ring_cmd.push = 1'b0;
      ring_cmd.pop  = 1'b0;
      status_in     = ST_BAD_SLOT;
      slot_out_in   = '0;
      id_out_in     = '0;
      case (s1_mode_ff)
         MODE_ARRIVE: begin
            id_out_in = s1_id_ff;
            if (free_found) begin
               map_set     = commit;
               map_idx     = free_idx;
               status_in   = ST_PLACED;
               slot_out_in = SLOT_NUM_W'(32'(free_idx) + 1);
            end else if (ring_stat.full) begin
               status_in = ST_DROPPED;
            end else begin
               ring_cmd.push = commit;
               status_in     = ST_QUEUED;
            end
         end
         MODE_RELEASE: begin
            if (!bad_slot) begin
               slot_out_in = s1_slot_ff;
               if (ring_stat.empty) begin
                  map_clr   = commit;
                  status_in = ST_FREED;
               end else begin
                  map_set      = commit;
                  ring_cmd.pop = commit;
                  status_in    = ST_REFILLED;
                  id_out_in    = head_data;
               end
            end
         end
         default: begin
            status_in = ST_BAD_SLOT;
         end
      endcase
   end

   always_comb begin
      level = fill;
      if (ring_cmd.push) begin
         level = fill + 1'b1;
      end else if (ring_cmd.pop) begin
         level = fill - 1'b1;
      end
   end

   bwq_slot_map #(
      .SLOTS (SLOTS)
   ) u_slot_map (
      .clock      (clock),
      .reset      (reset),
      .set_en     (map_set),
      .clr_en     (map_clr),
      .idx        (map_idx),
      .count      (count_eff),
      .free_found (free_found),
      .free_idx   (free_idx)
   );

   bwq_wait_ring #(
      .WAIT_DEPTH (WAIT_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_wait_ring (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ring_cmd),
      .wdata     (s1_id_ff),
      .stat      (ring_stat),
      .head_data (head_data),
      .fill      (fill)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff      <= status_in;
         rsp_slot_out_ff    <= slot_out_in;
         rsp_id_out_ff      <= id_out_in;
         rsp_queue_level_ff <= LEVEL_W'(32'(level));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_out    = rsp_slot_out_ff;
   assign rsp_id_out      = rsp_id_out_ff;
   assign rsp_queue_level = rsp_queue_level_ff;

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      !(ring_cmd.push && ring_cmd.pop))
      else $error("wait queue pushed and popped in one transfer");

   assert property (@(posedge clock) disable iff (reset)
      ring_cmd.push |-> !ring_stat.full)
      else $error("push into a full wait queue");

   assert property (@(posedge clock) disable iff (reset)
      ring_cmd.pop |-> !ring_stat.empty)
      else $error("pop from an empty wait queue");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled while a stage is free");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_PLACED || rsp_status == ST_REFILLED))
      |-> (rsp_slot_out != '0))
      else $error("placed or refilled result without a slot");
`endif

endmodule

// ===== tb/sv/berth_result_checker.sv =====
// checker for the berth allocator: watches both channels and the csr port, predicts and compares
`timescale 1ns / 1ps

module berth_result_checker import bwq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_mode,
   input  logic [ID_BITS_DEF-1:0] req_requester_id,
   input  logic [SLOT_NUM_W-1:0]  req_slot_number,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [STATUS_W-1:0]    rsp_status,
   input  logic [SLOT_NUM_W-1:0]  rsp_slot_out,
   input  logic [ID_BITS_DEF-1:0] rsp_id_out,
   input  logic [LEVEL_W-1:0]     rsp_queue_level,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_AW-1:0]      paddr,
   input  logic [CSR_DW-1:0]      pwdata,
   input  logic [CSR_DW-1:0]      prdata,
   input  logic                   pready,
   output int                     fail_count,
   output int                     checked_count,
   output int                     pending_count,
   output logic [5:0]             status_hit
);

   localparam logic [CSR_AW-1:0] SLOT_COUNT_ADDR = CSR_AW'(4 * REG_SLOT_COUNT);

   typedef struct packed {
      status_type              status;
      logic [SLOT_NUM_W-1:0]   slot;
      logic [ID_BITS_DEF-1:0]  id;
      logic [LEVEL_W-1:0]      level;
   } berth_result_type;

   logic [COUNT_W-1:0]     slot_count_q;
   logic                   occupied [SLOTS_DEF];
   logic [ID_BITS_DEF-1:0] owner [SLOTS_DEF];
   logic [ID_BITS_DEF-1:0] waitq [WAIT_DEPTH_DEF];
   logic [3:0]             wait_head;
   logic [3:0]             wait_tail;
   logic [4:0]             wait_fill;

   berth_result_type awaited_results [$];
   int                     mismatches = 0;
   int                     results_checked = 0;
   logic [5:0]             seen_status = '0;

   function automatic berth_result_type step_berths(input mode_type m,
                                                    input logic [ID_BITS_DEF-1:0] id,
                                                    input logic [SLOT_NUM_W-1:0] sn);
      berth_result_type r;
      int               in_use;
      int               i;
      bit               found;
      logic [3:0]       k;
      if (slot_count_q == 0)
         in_use = 1;
      else if (slot_count_q > SLOTS_DEF)
         in_use = SLOTS_DEF;
      else
         in_use = slot_count_q;
      r = '0;
      found = 1'b0;
      k = 4'(sn - 5'd1);
      if (m == MODE_ARRIVE) begin
         r.id = id;
         for (i = 0; i < SLOTS_DEF; i++) begin
            if (!found && i < in_use && !occupied[i]) begin
               found = 1'b1;
               occupied[i] = 1'b1;
               owner[i] = id;
               r.status = ST_PLACED;
               r.slot = SLOT_NUM_W'(i + 1);
            end
         end
         if (!found) begin
            if (wait_fill >= WAIT_DEPTH_DEF) begin
               r.status = ST_DROPPED;
            end else begin
               waitq[wait_tail] = id;
               wait_tail = wait_tail + 4'd1;
               wait_fill = wait_fill + 5'd1;
               r.status = ST_QUEUED;
            end
         end
      end else if (sn == 0 || sn > in_use) begin
         r.status = ST_BAD_SLOT;
      end else if (wait_fill == 0) begin
         occupied[k] = 1'b0;
         owner[k] = '0;
         r.status = ST_FREED;
         r.slot = sn;
      end else begin
         occupied[k] = 1'b1;
         owner[k] = waitq[wait_head];
         wait_head = wait_head + 4'd1;
         wait_fill = wait_fill - 5'd1;
         r.status = ST_REFILLED;
         r.slot = sn;
         r.id = owner[k];
      end
      r.level = wait_fill;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      berth_result_type want;
      berth_result_type got;
      int               i;
      if (reset) begin
         slot_count_q = SLOT_COUNT_RST;
         for (i = 0; i < SLOTS_DEF; i++) begin
            occupied[i] = 1'b0;
            owner[i] = '0;
         end
         for (i = 0; i < WAIT_DEPTH_DEF; i++)
            waitq[i] = '0;
         wait_head = '0;
         wait_tail = '0;
         wait_fill = '0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status = status_type'(rsp_status);
            got.slot = rsp_slot_out;
            got.id = rsp_id_out;
            got.level = rsp_queue_level;
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer: status %0d slot %0d id %h level %0d",
                           got.status, got.slot, got.id, got.level);
            end else begin
               want = awaited_results.pop_front();
               results_checked++;
               seen_status[want.status] = 1'b1;
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.id !== want.id || got.level !== want.level) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected status %0d slot %0d id %h level %0d, ",
                               "got status %0d slot %0d id %h level %0d"},
                              want.status, want.slot, want.id, want.level,
                              got.status, got.slot, got.id, got.level);
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_results.insert(awaited_results.size(),
                                   step_berths(mode_type'(req_mode), req_requester_id,
                                               req_slot_number));
         if (psel && penable && pready && paddr == SLOT_COUNT_ADDR) begin
            if (pwrite) begin
               slot_count_q = pwdata[COUNT_W-1:0];
            end else if (prdata !== CSR_DW'(slot_count_q)) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("slot_count readback: expected %0d, got %0d", slot_count_q, prdata);
            end
         end
      end
      fail_count    <= mismatches;
      checked_count <= results_checked;
      pending_count <= awaited_results.size();
      status_hit    <= seen_status;
   end

endmodule

// ===== tb/sv/berth_allocator_with_wait_queue_tb.sv =====
// testbench top for the berth allocator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module berth_allocator_with_wait_queue_tb import bwq_pkg::*;;

   localparam logic [CSR_AW-1:0] SLOT_COUNT_ADDR = CSR_AW'(4 * REG_SLOT_COUNT);
   localparam int ITEM_TARGET = 1250;
   localparam int LONG_HOLD   = 48;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_mode = 1'b0;
   logic [ID_BITS_DEF-1:0] req_requester_id = '0;
   logic [SLOT_NUM_W-1:0]  req_slot_number = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [SLOT_NUM_W-1:0]  rsp_slot_out;
   logic [ID_BITS_DEF-1:0] rsp_id_out;
   logic [LEVEL_W-1:0]     rsp_queue_level;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [CSR_AW-1:0]      paddr = '0;
   logic [CSR_DW-1:0]      pwdata = '0;
   logic [CSR_DW-1:0]      prdata;
   logic                   pready;

   int         fail_count;
   int         checked_count;
   int         pending_count;
   logic [5:0] status_hit;

   logic rsp_hold = 1'b0;
   logic recv_quiet = 1'b0;
   bit   send_quiet = 1'b0;
   int   recv_wait = 0;
   int   items_sent = 0;
   int   settings_made = 0;
   event holdoff_kick;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   berth_allocator_with_wait_queue DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_requester_id(req_requester_id), .req_slot_number(req_slot_number),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_slot_out(rsp_slot_out), .rsp_id_out(rsp_id_out),
      .rsp_queue_level(rsp_queue_level),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   berth_result_checker berth_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_requester_id(req_requester_id), .req_slot_number(req_slot_number),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_slot_out(rsp_slot_out), .rsp_id_out(rsp_id_out),
      .rsp_queue_level(rsp_queue_level),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .fail_count(fail_count), .checked_count(checked_count),
      .pending_count(pending_count), .status_hit(status_hit)
   );

   // result side: random wait after each transfer unless recv_quiet is set, long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         recv_wait = 0;
         rsp_stall <= 1'b0;
      end else if (rsp_hold) begin
         rsp_stall <= 1'b1;
      end else if (recv_wait > 0) begin
         recv_wait--;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall && !recv_quiet) begin
         recv_wait = $urandom_range(0, 7);
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      forever begin
         @(holdoff_kick);
         rsp_hold <= 1'b1;
         repeat (LONG_HOLD) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_item(input mode_type m, input logic [ID_BITS_DEF-1:0] id,
                            input logic [SLOT_NUM_W-1:0] sn);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_requester_id <= id;
      req_slot_number <= sn;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic set_slot_count(input logic [COUNT_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SLOT_COUNT_ADDR;
      pwdata <= CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // read back
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      settings_made++;
   endtask

   task automatic random_item(input int arrive_pct, input int in_use);
      mode_type               m;
      logic [ID_BITS_DEF-1:0] id;
      logic [SLOT_NUM_W-1:0]  sn;
      m = ($urandom_range(0, 99) < arrive_pct) ? MODE_ARRIVE : MODE_RELEASE;
      case ($urandom_range(0, 15))
         0: id = '0;
         1: id = '1;
         default: id = ID_BITS_DEF'($urandom);
      endcase
      if ($urandom_range(0, 9) == 0)
         sn = SLOT_NUM_W'($urandom_range(0, 31));
      else
         sn = SLOT_NUM_W'($urandom_range(1, in_use));
      send_item(m, id, sn);
   endtask

   initial begin : stimulus
      int                 phase;
      int                 in_use;
      int                 arrive_pct;
      int                 length;
      logic               quiet_rx;
      logic [COUNT_W-1:0] value;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero count acts as one slot
      set_slot_count('0);
      send_item(MODE_ARRIVE, 16'h0000, 5'd0);
      send_item(MODE_ARRIVE, 16'hFFFF, 5'd31);
      send_item(MODE_ARRIVE, 16'hA5A5, 5'd16);
      send_item(MODE_RELEASE, 16'hFFFF, 5'd1);
      send_item(MODE_RELEASE, 16'h0000, 5'd2);
      send_item(MODE_RELEASE, 16'h5A5A, 5'd0);
      send_item(MODE_RELEASE, 16'h0000, 5'd1);
      send_item(MODE_RELEASE, 16'h0000, 5'd1);
      send_item(MODE_RELEASE, 16'hFFFF, 5'd1);
      drain_results();

      // count above the built depth acts as the full depth
      set_slot_count(5'd31);
      send_item(MODE_RELEASE, 16'h0001, 5'd16);
      send_item(MODE_RELEASE, 16'h8000, 5'd17);
      send_item(MODE_RELEASE, 16'h0000, 5'd31);
      send_item(MODE_ARRIVE, 16'h5A5A, 5'd0);
      send_item(MODE_ARRIVE, 16'h1234, 5'd15);
      send_item(MODE_RELEASE, 16'h0000, 5'd1);
      send_item(MODE_ARRIVE, 16'hFFFF, 5'd10);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain_results();
         case (phase)
            0: value = 5'd1;
            1: value = 5'd16;
            2: value = 5'd17;
            3: value = 5'd2;
            default: begin
               if ($urandom_range(0, 7) == 0)
                  value = COUNT_W'($urandom_range(0, 31));
               else
                  value = COUNT_W'($urandom_range(1, 16));
            end
         endcase
         set_slot_count(value);
         if (value == 0)
            in_use = 1;
         else if (value > SLOTS_DEF)
            in_use = SLOTS_DEF;
         else
            in_use = value;
         case ($urandom_range(0, 3))
            0: arrive_pct = 30;
            1: arrive_pct = 50;
            2: arrive_pct = 65;
            default: arrive_pct = 80;
         endcase
         length = $urandom_range(60, 120);
         send_quiet = ($urandom_range(0, 3) == 0);
         quiet_rx = ($urandom_range(0, 3) == 0);
         if (phase == 2 || phase == 6) begin
            send_quiet = 1'b1;
            quiet_rx = 1'b0;
            -> holdoff_kick;
         end
         recv_quiet <= quiet_rx;
         repeat (length) random_item(arrive_pct, in_use);
         phase++;
      end

      send_quiet = 1'b0;
      drain_results();
      repeat (10) @(posedge clock);
      $display("covered %0d item transfers and %0d checked results over %0d slot_count settings",
               items_sent, checked_count, settings_made);
      $display("status codes seen (bit per code, placed is bit 0): %b", status_hit);
      if (fail_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== berth_allocator_with_wait_queue.f =====
rtl/bwq_pkg.sv
rtl/bwq_slot_map.sv
rtl/bwq_wait_ring.sv
rtl/berth_allocator_with_wait_queue.sv
tb/sv/berth_result_checker.sv
tb/sv/berth_allocator_with_wait_queue_tb.sv
